// ===== hw/rtl/lsed_pkg.sv =====
package lsed_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DIV_BITS = 32 + FRAC_BITS;
	localparam int DIV_LAT = DIV_BITS + 2;
	localparam int MUL_LAT = 5;

	localparam logic signed [63:0] ONE_Q = 64'sd1 <<< FRAC_BITS;
	localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;
	localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

	typedef enum logic [1:0] {
		REG_INV_DX      = 2'd0,
		REG_CELL_VOLUME = 2'd1,
		REG_FLUID_ON    = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic signed [31:0] fluid_energy;
		logic [30:0]        lorentz_factor;
		logic signed [31:0] kappa_factor;
		logic signed [31:0] field_momentum;
		logic signed [31:0] phi_x_plus;
		logic signed [31:0] phi_x_minus;
		logic signed [31:0] phi_y_plus;
		logic signed [31:0] phi_y_minus;
		logic signed [31:0] phi_z_plus;
		logic signed [31:0] phi_z_minus;
	} site_t;

	typedef struct packed {
		logic signed [31:0] density;
		logic               saturated;
	} result_t;

	typedef struct packed {
		logic               ovf;
		logic signed [63:0] value;
	} sat_t;

	function automatic sat_t sat_add(input logic signed [63:0] a, input logic signed [63:0] b);
		logic [64:0] s;
		sat_t r;
		s = {a[63], a} + {b[63], b};
		r.ovf = s[64] ^ s[63];
		r.value = r.ovf ? (s[64] ? S64_MIN : S64_MAX) : s[63:0];
		return r;
	endfunction

endpackage

// ===== hw/rtl/lsed_delay.sv =====
module lsed_delay #(
	parameter int W = 1,
	parameter int N = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);
	logic [W-1:0] sr_q [N];

	always_ff @(posedge clk) begin
		if (en) begin
			sr_q[0] <= d;
			for (int i = 1; i < N; i++) begin
				sr_q[i] <= sr_q[i-1];
			end
		end
	end

	assign q = sr_q[N-1];
endmodule

// ===== hw/rtl/lsed_div.sv =====
module lsed_div (
	input  logic                             clk,
	input  logic                             en,
	input  logic signed [31:0]               e,
	input  logic [30:0]                      w,
	output logic signed [lsed_pkg::DIV_BITS:0] r
);
	import lsed_pkg::*;

	logic [31:0]          abs_e;
	logic [DIV_BITS-1:0]  num_q [DIV_BITS+1];
	logic [30:0]          rem_q [DIV_BITS];
	logic [30:0]          w_q   [DIV_BITS];
	logic                 neg_q [DIV_BITS+1];
	logic                 zero_q [DIV_BITS+1];
	logic signed [DIV_BITS:0] qs;
	logic signed [DIV_BITS:0] r_q;

	assign abs_e = e[31] ? 32'(-e) : 32'(e);

	always_ff @(posedge clk) begin
		if (en) begin
			num_q[0]  <= {abs_e, {FRAC_BITS{1'b0}}};
			rem_q[0]  <= '0;
			w_q[0]    <= w;
			neg_q[0]  <= e[31];
			zero_q[0] <= (w == '0);
		end
	end

	// restoring division, one quotient bit per stage
	for (genvar k = 0; k < DIV_BITS; k++) begin : g_bit
		logic [31:0] trial;
		logic        ge;
		assign trial = {rem_q[k], num_q[k][DIV_BITS-1]};
		assign ge = trial >= {1'b0, w_q[k]};
		always_ff @(posedge clk) begin
			if (en) begin
				num_q[k+1]  <= {num_q[k][DIV_BITS-2:0], ge};
				neg_q[k+1]  <= neg_q[k];
				zero_q[k+1] <= zero_q[k];
			end
		end
		if (k < DIV_BITS - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_q[k+1] <= ge ? 31'(trial - {1'b0, w_q[k]}) : 31'(trial);
					w_q[k+1]   <= w_q[k];
				end
			end
		end
	end

	assign qs = {1'b0, num_q[DIV_BITS]};

	always_ff @(posedge clk) begin
		if (en) begin
			r_q <= zero_q[DIV_BITS] ? '0 : (neg_q[DIV_BITS] ? -qs : qs);
		end
	end

	assign r = r_q;
endmodule

// ===== hw/rtl/lsed_mulq.sv =====
module lsed_mulq #(
	parameter int WA = 32,
	parameter int WB = 32
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [WA-1:0] a,
	input  logic signed [WB-1:0] b,
	output logic signed [63:0]   p,
	output logic                 clip
);
	import lsed_pkg::*;

	localparam int NA = (WA + 31) / 32;
	localparam int NB = (WB + 31) / 32;
	localparam int LA = NA * 32;
	localparam int LB = NB * 32;
	localparam int PW = 128;
	localparam int HW = PW - FRAC_BITS - 64;

	logic [WA-1:0]      abs_a;
	logic [WB-1:0]      abs_b;
	logic [LA-1:0]      ma_s1;
	logic [LB-1:0]      mb_s1;
	logic               neg_s1, neg_s2, neg_s3, neg_s4;
	logic [63:0]        pp_s2 [NA][NB];
	logic [PW-1:0]      row   [NA];
	logic [PW-1:0]      row_s3 [NA];
	logic [PW-1:0]      prod;
	logic [PW-1:0]      prod_s4;
	logic [HW-1:0]      rhi;
	logic [63:0]        rlo;
	logic signed [63:0] res;
	logic               res_clip;
	logic signed [63:0] p_s5;
	logic               clip_s5;

	assign abs_a = a[WA-1] ? WA'(-a) : WA'(a);
	assign abs_b = b[WB-1] ? WB'(-b) : WB'(b);

	always_comb begin
		for (int i = 0; i < NA; i++) begin
			row[i] = '0;
			for (int j = 0; j < NB; j++) begin
				row[i] = row[i] + (PW'(pp_s2[i][j]) << (32 * j));
			end
		end
	end

	always_comb begin
		prod = '0;
		for (int i = 0; i < NA; i++) begin
			prod = prod + (row_s3[i] << (32 * i));
		end
	end

	// magnitude truncated by FRAC_BITS, then clipped to the signed 64-bit range
	always_comb begin
		rhi = prod_s4[PW-1:FRAC_BITS+64];
		rlo = prod_s4[FRAC_BITS+63:FRAC_BITS];
		res_clip = 1'b0;
		if (|rhi) begin
			res_clip = 1'b1;
			res = neg_s4 ? S64_MIN : S64_MAX;
		end else if (!neg_s4 && rlo[63]) begin
			res_clip = 1'b1;
			res = S64_MAX;
		end else if (neg_s4 && rlo > 64'h8000_0000_0000_0000) begin
			res_clip = 1'b1;
			res = S64_MIN;
		end else begin
			res = neg_s4 ? -rlo : rlo;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ma_s1   <= LA'(abs_a);
			mb_s1   <= LB'(abs_b);
			neg_s1  <= a[WA-1] ^ b[WB-1];
			neg_s2  <= neg_s1;
			neg_s3  <= neg_s2;
			neg_s4  <= neg_s3;
			for (int i = 0; i < NA; i++) begin
				for (int j = 0; j < NB; j++) begin
					pp_s2[i][j] <= 64'(ma_s1[32*i +: 32]) * 64'(mb_s1[32*j +: 32]);
				end
				row_s3[i] <= row[i];
			end
			prod_s4 <= prod;
			p_s5    <= res;
			clip_s5 <= res_clip;
		end
	end

	assign p = p_s5;
	assign clip = clip_s5;
endmodule

// ===== hw/rtl/lattice_site_energy_density.sv =====
// Energy density of one lattice site, signed Q16.16, saturated.
// Site channel: site_valid / site_stall carry one site_t beat (fluid E, W, kappa,
// momentum and six neighbour field values). A beat is taken when valid is high
// and stall is low.
// Result channel: result_valid / result_stall carry one result_t beat per site,
// in order: density and a saturated flag set when any clipping took place.
// Config channel: cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high. Write only while no site is in flight.
// Depth: a site's result passes the 48-stage restoring divider for E/W, then three
// chained five-stage multipliers, plus the saturating adds.
// Throughput: one site per cycle while site_stall is low.
// Stall: when result_stall holds a beat, the next finished result goes into a
// skid register; once that is full the whole pipeline freezes and site_stall
// rises. Nothing is dropped or repeated.
// Reset: clears all valid state and loads inv_dx = 1.0, cell_volume = 1.0,
// fluid terms on.
module lattice_site_energy_density (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              site_valid,
	output logic              site_stall,
	input  lsed_pkg::site_t   site,
	output logic              result_valid,
	input  logic              result_stall,
	output lsed_pkg::result_t result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [30:0]       cfg_data
);
	import lsed_pkg::*;

	localparam int M = MUL_LAT;
	localparam int D = DIV_LAT;
	localparam int T_T1 = D + M;
	localparam int T_KIN = D + 3 * M;
	localparam int T_A = T_KIN + 1;
	localparam int T_B = T_A + 1;
	localparam int T_C = T_B + 1;
	localparam int T_FIN = T_C + 1;

	logic [30:0] inv_dx_q;
	logic [30:0] cell_volume_q;
	logic        fluid_on_q;

	logic        en;
	logic [T_FIN:0] vld_q;
	site_t       site_s1;

	logic signed [31:0] vol, idx;

	// fluid path
	logic signed [DIV_BITS:0] r;
	logic signed [31:0] kap_d;
	logic signed [63:0] rest, t1, ww, t2, kin;
	logic               rest_c, t1_c, ww_c, t2_c, kin_c;
	sat_t               ww1_sum;
	logic signed [63:0] ww1_s7;
	logic               ww1c_s7;
	logic signed [63:0] ww1_d;
	logic               ww1c_d;
	logic               f1;
	logic signed [63:0] rest_d;
	logic               f1_d, t2c_d;
	sat_t               a_sum;
	logic signed [63:0] a_s67;
	logic               ac_s67;

	// momentum path
	logic signed [63:0] pp, momv, mom_d;
	logic               pp_c, ppc_d, momv_c, momc_d;
	sat_t               b_sum;
	logic signed [63:0] b_s68;
	logic               bc_s68;

	// gradient path
	logic signed [32:0] d_s2 [3];
	logic signed [63:0] g [3];
	logic signed [63:0] gsq [3];
	logic [2:0]         g_c, gc_d, gsq_c;
	sat_t               gs1_sum, gs2_sum;
	logic signed [63:0] gs1_s13, gz_s13, gs2_s14;
	logic               gc1_s13, gc2_s14;
	logic               gc2_d;
	logic signed [63:0] gv, grad_d;
	logic               gv_c, gradc_d;
	sat_t               c_sum;
	logic signed [63:0] c_s69;
	logic               cc_s69;
	logic               fits;
	result_t            fin_s70;

	// output register and skid
	logic    res_valid_q, skid_valid_q;
	result_t res_q, skid_q;
	logic    out_free, push;

	assign en = ~skid_valid_q;
	assign site_stall = skid_valid_q;
	assign cfg_ready = 1'b1;
	assign vol = {1'b0, cell_volume_q};
	assign idx = {1'b0, inv_dx_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_dx_q      <= 31'(ONE_Q);
			cell_volume_q <= 31'(ONE_Q);
			fluid_on_q    <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_INV_DX:      inv_dx_q <= cfg_data;
				REG_CELL_VOLUME: cell_volume_q <= cfg_data;
				REG_FLUID_ON:    fluid_on_q <= cfg_data[0];
				default:         ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[T_FIN-1:0], site_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			site_s1 <= site;
		end
	end

	// ---- fluid rest and kinetic terms
	lsed_div u_div (
		.clk (clk), .en (en),
		.e   (site_s1.fluid_energy), .w (site_s1.lorentz_factor),
		.r   (r)
	);

	lsed_delay #(.W(32), .N(D)) u_kap_dly (
		.clk (clk), .en (en), .d (site_s1.kappa_factor), .q (kap_d)
	);

	lsed_mulq #(.WA(DIV_BITS + 1), .WB(32)) u_rest (
		.clk (clk), .en (en), .a (r), .b (vol), .p (rest), .clip (rest_c)
	);

	lsed_mulq #(.WA(32), .WB(DIV_BITS + 1)) u_t1 (
		.clk (clk), .en (en), .a (kap_d), .b (r), .p (t1), .clip (t1_c)
	);

	lsed_mulq #(.WA(32), .WB(32)) u_ww (
		.clk (clk), .en (en),
		.a ({1'b0, site_s1.lorentz_factor}), .b ({1'b0, site_s1.lorentz_factor}),
		.p (ww), .clip (ww_c)
	);

	assign ww1_sum = sat_add(ww, -ONE_Q);

	always_ff @(posedge clk) begin
		if (en) begin
			ww1_s7  <= ww1_sum.value;
			ww1c_s7 <= ww_c | ww1_sum.ovf;
		end
	end

	lsed_delay #(.W(65), .N(T_T1 - (M + 1))) u_ww1_dly (
		.clk (clk), .en (en), .d ({ww1c_s7, ww1_s7}), .q ({ww1c_d, ww1_d})
	);

	lsed_mulq #(.WA(64), .WB(64)) u_t2 (
		.clk (clk), .en (en), .a (t1), .b (ww1_d), .p (t2), .clip (t2_c)
	);

	assign f1 = t1_c | rest_c | ww1c_d;

	lsed_delay #(.W(65), .N(2 * M)) u_rest_dly (
		.clk (clk), .en (en), .d ({f1, rest}), .q ({f1_d, rest_d})
	);

	lsed_delay #(.W(1), .N(M)) u_t2c_dly (
		.clk (clk), .en (en), .d (t2_c), .q (t2c_d)
	);

	lsed_mulq #(.WA(64), .WB(32)) u_kin (
		.clk (clk), .en (en), .a (t2), .b (vol), .p (kin), .clip (kin_c)
	);

	assign a_sum = sat_add(rest_d, kin);

	always_ff @(posedge clk) begin
		if (en) begin
			a_s67  <= fluid_on_q ? a_sum.value : '0;
			ac_s67 <= fluid_on_q & (f1_d | t2c_d | kin_c | a_sum.ovf);
		end
	end

	// ---- momentum term
	lsed_mulq #(.WA(32), .WB(32)) u_pp (
		.clk (clk), .en (en),
		.a (site_s1.field_momentum), .b (site_s1.field_momentum),
		.p (pp), .clip (pp_c)
	);

	lsed_delay #(.W(1), .N(M)) u_ppc_dly (
		.clk (clk), .en (en), .d (pp_c), .q (ppc_d)
	);

	lsed_mulq #(.WA(64), .WB(32)) u_mom (
		.clk (clk), .en (en), .a (pp), .b (vol), .p (momv), .clip (momv_c)
	);

	lsed_delay #(.W(65), .N(T_A - 2 * M)) u_mom_dly (
		.clk (clk), .en (en), .d ({momv_c | ppc_d, momv}), .q ({momc_d, mom_d})
	);

	assign b_sum = sat_add(a_s67, mom_d >>> 1);

	always_ff @(posedge clk) begin
		if (en) begin
			b_s68  <= b_sum.value;
			bc_s68 <= ac_s67 | momc_d | b_sum.ovf;
		end
	end

	// ---- gradient terms
	always_ff @(posedge clk) begin
		if (en) begin
			d_s2[0] <= $signed({site_s1.phi_x_plus[31], site_s1.phi_x_plus})
				- $signed({site_s1.phi_x_minus[31], site_s1.phi_x_minus});
			d_s2[1] <= $signed({site_s1.phi_y_plus[31], site_s1.phi_y_plus})
				- $signed({site_s1.phi_y_minus[31], site_s1.phi_y_minus});
			d_s2[2] <= $signed({site_s1.phi_z_plus[31], site_s1.phi_z_plus})
				- $signed({site_s1.phi_z_minus[31], site_s1.phi_z_minus});
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_axis
		lsed_mulq #(.WA(33), .WB(32)) u_g (
			.clk (clk), .en (en), .a (d_s2[i]), .b (idx), .p (g[i]), .clip (g_c[i])
		);
		lsed_mulq #(.WA(64), .WB(64)) u_gsq (
			.clk (clk), .en (en), .a (g[i]), .b (g[i]), .p (gsq[i]), .clip (gsq_c[i])
		);
	end

	lsed_delay #(.W(3), .N(M)) u_gc_dly (
		.clk (clk), .en (en), .d (g_c), .q (gc_d)
	);

	assign gs1_sum = sat_add(gsq[0], gsq[1]);
	assign gs2_sum = sat_add(gs1_s13, gz_s13);

	always_ff @(posedge clk) begin
		if (en) begin
			gs1_s13 <= gs1_sum.value;
			gz_s13  <= gsq[2];
			gc1_s13 <= (|gsq_c) | (|gc_d) | gs1_sum.ovf;
			gs2_s14 <= gs2_sum.value;
			gc2_s14 <= gc1_s13 | gs2_sum.ovf;
		end
	end

	lsed_delay #(.W(1), .N(M)) u_gc2_dly (
		.clk (clk), .en (en), .d (gc2_s14), .q (gc2_d)
	);

	lsed_mulq #(.WA(64), .WB(32)) u_gv (
		.clk (clk), .en (en), .a (gs2_s14), .b (vol), .p (gv), .clip (gv_c)
	);

	lsed_delay #(.W(65), .N(T_B - (3 + 3 * M))) u_grad_dly (
		.clk (clk), .en (en), .d ({gv_c | gc2_d, gv}), .q ({gradc_d, grad_d})
	);

	assign c_sum = sat_add(b_s68, grad_d >>> 3);

	always_ff @(posedge clk) begin
		if (en) begin
			c_s69  <= c_sum.value;
			cc_s69 <= bc_s68 | gradc_d | c_sum.ovf;
		end
	end

	// ---- final 32-bit clip
	assign fits = (c_s69[63:31] == {33{c_s69[31]}});

	always_ff @(posedge clk) begin
		if (en) begin
			fin_s70.density   <= fits ? c_s69[31:0] : (c_s69[63] ? S32_MIN : S32_MAX);
			fin_s70.saturated <= cc_s69 | ~fits;
		end
	end

	// ---- output register with skid
	assign out_free = ~res_valid_q | ~result_stall;
	assign push = en & vld_q[T_FIN];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				res_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				res_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				res_q <= skid_q;
			end else if (push) begin
				res_q <= fin_s70;
			end
		end else if (push) begin
			skid_q <= fin_s70;
		end
	end

	assign result_valid = res_valid_q;
	assign result = res_q;
endmodule

// ===== verif/tb_lattice_site_energy_density.sv =====
module tb_lattice_site_energy_density;
	import lsed_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        site_valid;
	logic        site_stall;
	site_t       site;
	logic        result_valid;
	logic        result_stall;
	result_t     result;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [30:0] cfg_data;

	lattice_site_energy_density u_dut (
		.clk(clk), .arst_n(arst_n),
		.site_valid(site_valid), .site_stall(site_stall), .site(site),
		.result_valid(result_valid), .result_stall(result_stall), .result(result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor copy of the registers
	logic [30:0] m_inv_dx;
	logic [30:0] m_vol;
	logic        m_fluid;

	result_t     density_q[$];
	int          mismatches;
	int          send_idle_pct;
	int          recv_stall_pct;
	int          hold_cycles;

	localparam logic [63:0] U63_LIM = 64'h8000_0000_0000_0000;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [63:0] mag64(input logic signed [63:0] v);
		return v[63] ? (64'd0 - v) : v;
	endfunction

	function automatic logic signed [63:0] from_mag(input logic neg, input logic [63:0] m,
			inout logic clip);
		logic [63:0] lim;
		lim = neg ? U63_LIM : {1'b0, {63{1'b1}}};
		if (m > lim) begin
			m = lim;
			clip = 1'b1;
		end
		return neg ? -$signed(m) : $signed(m);
	endfunction

	function automatic logic signed [63:0] qmul(input logic signed [63:0] a,
			input logic signed [63:0] b, inout logic clip);
		logic         neg;
		logic [127:0] p;
		logic [127:0] r;
		neg = a[63] != b[63];
		p = {64'd0, mag64(a)} * {64'd0, mag64(b)};
		r = p >> FRAC_BITS;
		if (r[127:64] != 0) begin
			clip = 1'b1;
			return neg ? S64_MIN : S64_MAX;
		end
		return from_mag(neg, r[63:0], clip);
	endfunction

	function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
			input logic signed [63:0] b, inout logic clip);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s > $signed({1'b0, S64_MAX})) begin
			clip = 1'b1;
			return S64_MAX;
		end
		if (s < $signed({1'b1, S64_MIN})) begin
			clip = 1'b1;
			return S64_MIN;
		end
		return s[63:0];
	endfunction

	function automatic logic signed [63:0] grad_term(input logic signed [31:0] p,
			input logic signed [31:0] m, inout logic clip);
		logic signed [63:0] d;
		logic signed [63:0] g;
		d = 64'(p) - 64'(m);
		g = qmul(d, {33'd0, m_inv_dx}, clip);
		return qmul(g, g, clip);
	endfunction

	function automatic result_t site_density(input site_t s);
		logic               clip;
		logic signed [63:0] vol;
		logic signed [63:0] tot;
		logic signed [63:0] t;
		logic signed [63:0] r;
		logic signed [63:0] e;
		logic signed [63:0] w;
		logic [63:0]        q;
		result_t            o;
		clip = 1'b0;
		vol = {33'd0, m_vol};
		tot = 0;
		if (m_fluid) begin
			e = 64'(s.fluid_energy);
			w = {33'd0, s.lorentz_factor};
			r = 0;
			if (w != 0) begin
				q = (mag64(e) << FRAC_BITS) / w;
				r = from_mag(e[63], q, clip);
			end
			tot = sadd(tot, qmul(r, vol, clip), clip);
			t = qmul(64'(s.kappa_factor), r, clip);
			t = qmul(t, sadd(qmul(w, w, clip), -ONE_Q, clip), clip);
			tot = sadd(tot, qmul(t, vol, clip), clip);
		end
		t = qmul(qmul(64'(s.field_momentum), 64'(s.field_momentum), clip), vol, clip);
		tot = sadd(tot, t >>> 1, clip);
		t = grad_term(s.phi_x_plus, s.phi_x_minus, clip);
		t = sadd(t, grad_term(s.phi_y_plus, s.phi_y_minus, clip), clip);
		t = sadd(t, grad_term(s.phi_z_plus, s.phi_z_minus, clip), clip);
		t = qmul(t, vol, clip);
		tot = sadd(tot, t >>> 3, clip);
		if (tot > 64'(S32_MAX)) begin
			tot = 64'(S32_MAX);
			clip = 1'b1;
		end else if (tot < 64'(S32_MIN)) begin
			tot = 64'(S32_MIN);
			clip = 1'b1;
		end
		o.density = tot[31:0];
		o.saturated = clip;
		return o;
	endfunction

	task automatic send_site(input site_t s);
		while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
			site_valid <= 1'b0;
			@(negedge clk);
		end
		site <= s;
		site_valid <= 1'b1;
		@(posedge clk);
		while (site_stall) @(posedge clk);
		density_q.push_back(site_density(s));
		@(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [30:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_INV_DX: m_inv_dx = val;
			REG_CELL_VOLUME: m_vol = val;
			default: m_fluid = val[0];
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic drain;
		site_valid <= 1'b0;
		while (density_q.size() != 0) @(negedge clk);
		repeat (80) @(negedge clk);
	endtask

	function automatic logic [31:0] rnd_q(input int mode);
		case (mode)
			0: return $urandom();
			1: return 32'($signed($urandom_range(2 * 65536 * 64, 0)) - 65536 * 64);
			2: return 32'($signed($urandom_range(2 * 65536 * 4, 0)) - 65536 * 4);
			default: return $urandom_range(1, 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
		endcase
	endfunction

	function automatic site_t rnd_site();
		site_t s;
		int    m;
		m = $urandom_range(9, 0);
		m = m < 2 ? 0 : (m < 5 ? 1 : (m < 9 ? 2 : 3));
		s.fluid_energy = rnd_q(m);
		s.lorentz_factor = $urandom_range(9, 0) == 0 ? 31'($urandom())
			: 31'($urandom_range(65536 * 8, 65536));
		if ($urandom_range(29, 0) == 0) s.lorentz_factor = 31'($urandom_range(65535, 0));
		s.kappa_factor = rnd_q(m);
		s.field_momentum = rnd_q(m);
		s.phi_x_plus = rnd_q(m);
		s.phi_x_minus = rnd_q(m);
		s.phi_y_plus = rnd_q(m);
		s.phi_y_minus = rnd_q(m);
		s.phi_z_plus = rnd_q(m);
		s.phi_z_minus = rnd_q(m);
		return s;
	endfunction

	function automatic site_t fill_site(input logic [31:0] v, input logic [30:0] w);
		site_t s;
		s.fluid_energy = v;
		s.lorentz_factor = w;
		s.kappa_factor = v;
		s.field_momentum = v;
		s.phi_x_plus = v;
		s.phi_x_minus = ~v;
		s.phi_y_plus = ~v;
		s.phi_y_minus = v;
		s.phi_z_plus = v;
		s.phi_z_minus = 32'd0;
		return s;
	endfunction

	task automatic test_directed;
		site_t s;
		send_site(fill_site(32'd0, 31'd65536));
		send_site(fill_site(32'h0001_0000, 31'd65536));
		send_site(fill_site(32'hFFFF_0000, 31'd131072));
		send_site(fill_site(32'h7FFF_FFFF, 31'h7FFF_FFFF));
		send_site(fill_site(32'h8000_0000, 31'h7FFF_FFFF));
		send_site(fill_site(32'h8000_0000, 31'd0));
		send_site(fill_site(32'h0003_0000, 31'd0));
		send_site(fill_site(32'h0002_0000, 31'd32768));
		send_site(fill_site(32'hFFFE_8000, 31'd1));
		s = fill_site(32'h0000_0001, 31'd65536);
		s.phi_x_plus = 32'h7FFF_FFFF;
		s.phi_x_minus = 32'h8000_0000;
		send_site(s);
		drain();
		write_reg(REG_FLUID_ON, 31'd0);
		send_site(fill_site(32'h7FFF_FFFF, 31'd0));
		send_site(fill_site(32'h0001_8000, 31'd70000));
		drain();
		write_reg(REG_FLUID_ON, 31'd1);
		write_reg(REG_INV_DX, 31'd0);
		send_site(fill_site(32'h0004_0000, 31'd65536));
		drain();
		write_reg(REG_INV_DX, 31'h7FFF_FFFF);
		write_reg(REG_CELL_VOLUME, 31'h7FFF_FFFF);
		send_site(fill_site(32'h0000_0100, 31'd65536));
		send_site(fill_site(32'hFFFF_FF00, 31'd100000));
		drain();
		write_reg(REG_CELL_VOLUME, 31'd0);
		send_site(fill_site(32'h7FFF_FFFF, 31'd65536));
		drain();
		write_reg(REG_INV_DX, 31'd1);
		write_reg(REG_CELL_VOLUME, 31'd1);
		send_site(fill_site(32'h7FFF_FFFF, 31'd65536));
		drain();
	endtask

	task automatic test_random(input int n, input int idle, input int stl);
		send_idle_pct = idle;
		recv_stall_pct = stl;
		write_reg(REG_INV_DX, $urandom_range(3, 0) == 0 ? 31'($urandom())
			: 31'($urandom_range(65536 * 4, 1)));
		write_reg(REG_CELL_VOLUME, $urandom_range(3, 0) == 0 ? 31'($urandom())
			: 31'($urandom_range(65536 * 4, 0)));
		write_reg(REG_FLUID_ON, 31'($urandom_range(3, 0) != 0));
		repeat (n) send_site(rnd_site());
		drain();
	endtask

	task automatic test_backpressure;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_cycles = 300;
		repeat (120) send_site(rnd_site());
		drain();
	endtask

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			result_stall <= 1'b1;
			hold_cycles <= hold_cycles - 1;
		end else begin
			result_stall <= recv_stall_pct > 0 && $urandom_range(99, 0) < recv_stall_pct;
		end
	end

	always @(posedge clk) begin
		result_t exp_r;
		if (arst_n && result_valid && !result_stall) begin
			if (density_q.size() == 0) begin
				mismatches = mismatches + 1;
				if (mismatches <= 10) $display("unexpected result beat %h", result);
			end else begin
				exp_r = density_q.pop_front();
				if (exp_r !== result) begin
					mismatches = mismatches + 1;
					if (mismatches <= 10)
						$display("mismatch: exp density %h sat %b, got density %h sat %b",
							exp_r.density, exp_r.saturated, result.density, result.saturated);
				end
			end
		end
	end

	initial begin
		#20000000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		site_valid = 1'b0;
		site = '0;
		result_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_INV_DX;
		cfg_data = '0;
		mismatches = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_cycles = 0;
		m_inv_dx = 31'd65536;
		m_vol = 31'd65536;
		m_fluid = 1'b1;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_random(250, 0, 0);
		test_random(250, 82, 0);
		test_random(250, 0, 82);
		test_random(250, 11, 11);
		test_backpressure();
		test_random(250, 0, 0);
		test_random(250, 82, 0);
		test_random(250, 0, 82);
		test_random(250, 11, 11);
		drain();
		if (mismatches == 0 && density_q.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/lsed_pkg.sv
hw/rtl/lsed_delay.sv
hw/rtl/lsed_div.sv
hw/rtl/lsed_mulq.sv
hw/rtl/lattice_site_energy_density.sv
verif/tb_lattice_site_energy_density.sv
